/* rtl/wsrd_pkg.sv */
// shared constants, types and helpers of the work-stealing range dispatcher
package wsrd_pkg;

	localparam int MAX_WORKERS = 16;
	localparam int WID_W       = $clog2(MAX_WORKERS);
	localparam int WCNT_W      = $clog2(MAX_WORKERS + 1);
	localparam int TASK_W      = 24;
	localparam int GRANTED_W   = TASK_W + 1;
	localparam int BURST       = 128;
	localparam int DIV_STEPS   = TASK_W;
	localparam int CNT_W       = 5;
	localparam int ACC_W       = TASK_W + WID_W;
	localparam int ENTRY_W     = 2 * TASK_W;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = TASK_W;

	localparam logic [TASK_W-1:0] BURST_TASKS = TASK_W'(BURST);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WORKER_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEAL_ENABLE = 2'd2;

	// request operations
	localparam logic OP_LAUNCH  = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic div_step;
		logic split_init;
		logic split_step;
		logic rd_own;
		logic own_apply;
		logic scan_skip;
		logic scan_rd;
		logic scan_chk;
		logic steal_apply;
		logic out_load;
	} wsrd_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_launch;
		logic id_ok;
		logic steal_on;
		logic own_empty;
		logic scan_end;
		logic scan_self;
		logic found;
		logic peer_big;
		logic div_last;
		logic split_last;
	} wsrd_sts_t;

	// zero counts as one worker, large counts saturate
	function automatic logic [WCNT_W-1:0] workers_in_use(input logic [WCNT_W-1:0] wc);
		logic [WCNT_W-1:0] w;
		w = wc;
		if (wc == '0) begin
			w = WCNT_W'(1);
		end else if (wc > WCNT_W'(MAX_WORKERS)) begin
			w = WCNT_W'(MAX_WORKERS);
		end
		return w;
	endfunction

endpackage

/* rtl/wsrd_ctrl.sv */
// sequencing state machine of the range dispatcher
module wsrd_ctrl
	import wsrd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  wsrd_sts_t sts,
	output wsrd_cmd_t cmd
);

	localparam logic [3:0] S_IDLE       = 4'd0;
	localparam logic [3:0] S_DECODE     = 4'd1;
	localparam logic [3:0] S_DIV        = 4'd2;
	localparam logic [3:0] S_SPLIT_INIT = 4'd3;
	localparam logic [3:0] S_SPLIT      = 4'd4;
	localparam logic [3:0] S_OWN        = 4'd5;
	localparam logic [3:0] S_SCAN_RD    = 4'd6;
	localparam logic [3:0] S_SCAN_CHK   = 4'd7;
	localparam logic [3:0] S_STEAL      = 4'd8;
	localparam logic [3:0] S_FINISH     = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_launch) begin
					state_d = S_DIV;
				end else if (!sts.id_ok) begin
					state_d = S_FINISH;
				end else begin
					cmd.rd_own = 1'b1;
					state_d    = S_OWN;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_SPLIT_INIT;
				end
			end
			S_SPLIT_INIT: begin
				cmd.split_init = 1'b1;
				state_d        = S_SPLIT;
			end
			S_SPLIT: begin
				cmd.split_step = 1'b1;
				if (sts.split_last) begin
					state_d = S_FINISH;
				end
			end
			S_OWN: begin
				cmd.own_apply = 1'b1;
				if (sts.steal_on && sts.own_empty) begin
					state_d = S_SCAN_RD;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_SCAN_RD: begin
				if (sts.scan_end) begin
					state_d = sts.found ? S_STEAL : S_FINISH;
				end else if (sts.scan_self) begin
					cmd.scan_skip = 1'b1;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				cmd.scan_chk = 1'b1;
				state_d      = sts.peer_big ? S_STEAL : S_SCAN_RD;
			end
			S_STEAL: begin
				cmd.steal_apply = 1'b1;
				state_d         = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// one request in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while one is in flight");

	// a result appears only when leaving the finish state
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result raised outside the finish state");

endmodule

/* rtl/wsrd_dp.sv */
// queue memory, launch divider, split sweep, grant arithmetic and result registers
module wsrd_dp
	import wsrd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  wsrd_cmd_t             cmd,
	output wsrd_sts_t             sts,
	input  logic                  op,
	input  logic [WID_W-1:0]      worker_id,
	input  logic [TASK_W-1:0]     task_count,
	input  logic [WCNT_W-1:0]     worker_count,
	input  logic                  steal_enable,
	output logic                  grant_valid,
	output logic [TASK_W-1:0]     grant_begin,
	output logic [TASK_W-1:0]     grant_end,
	output logic                  stolen,
	output logic                  all_done
);

	// queue memory: {front, back} per worker
	logic [ENTRY_W-1:0]     mem [MAX_WORKERS];
	logic [ENTRY_W-1:0]     rdata_q;
	logic                   rvld_q;
	logic [MAX_WORKERS-1:0] vld_q;

	logic                   op_q;
	logic [WID_W-1:0]       id_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   found_q;
	logic [MAX_WORKERS-1:0] done_q;
	logic [MAX_WORKERS-1:0] given_q;
	logic [GRANTED_W-1:0]   granted_q;
	logic [TASK_W-1:0]      launch_total_q;

	logic [TASK_W-1:0]      quo_q;
	logic [WCNT_W-1:0]      rem_q;
	logic [TASK_W-1:0]      per_q;
	logic [ACC_W-1:0]       acc_q;

	logic [WID_W-1:0]       peer_q;
	logic [TASK_W-1:0]      peer_front_q;
	logic [TASK_W-1:0]      peer_back_q;

	logic                   res_valid_q;
	logic [TASK_W-1:0]      res_begin_q;
	logic [TASK_W-1:0]      res_end_q;
	logic                   res_stolen_q;

	logic                   out_grant_q;
	logic [TASK_W-1:0]      out_begin_q;
	logic [TASK_W-1:0]      out_end_q;
	logic                   out_stolen_q;
	logic                   out_done_q;

	logic [WCNT_W-1:0]      w;
	logic [MAX_WORKERS-1:0] full_mask;
	logic [MAX_WORKERS-1:0] id_bit;
	logic [TASK_W-1:0]      ent_front;
	logic [TASK_W-1:0]      ent_back;
	logic                   own_ne;
	logic [TASK_W-1:0]      own_span;
	logic [TASK_W-1:0]      burst_end;
	logic                   p_ne;
	logic [TASK_W-1:0]      p_span;
	logic [TASK_W-1:0]      steal_begin;
	logic [WCNT_W:0]        div_tmp;
	logic                   div_ge;
	logic                   split_in_use;
	logic [ACC_W-1:0]       split_end_full;
	logic [TASK_W-1:0]      split_begin;
	logic [TASK_W-1:0]      split_end;

	logic                   mem_we;
	logic                   mem_re;
	logic [WID_W-1:0]       mem_addr;
	logic [ENTRY_W-1:0]     mem_wdata;
	logic                   set_given;
	logic                   set_done;
	logic                   scan_init;
	logic                   res_load;
	logic                   res_v;
	logic [TASK_W-1:0]      res_b;
	logic [TASK_W-1:0]      res_e;
	logic                   res_s;
	logic                   grant_add;
	logic [TASK_W-1:0]      grant_amt;

	assign w      = workers_in_use(worker_count);
	assign id_bit = MAX_WORKERS'(1) << id_q;

	// workers in use as a bit mask
	always_comb begin
		for (int i = 0; i < MAX_WORKERS; i++) begin
			full_mask[i] = (WCNT_W'(i) < w);
		end
	end

	// entry read back, never-written entries read as empty
	assign ent_front = rvld_q ? rdata_q[ENTRY_W-1:TASK_W] : '0;
	assign ent_back  = rvld_q ? rdata_q[TASK_W-1:0] : '0;

	// own queue burst
	assign own_ne    = ent_front < ent_back;
	assign own_span  = ent_back - ent_front;
	assign burst_end = (own_span > BURST_TASKS) ? ent_front + BURST_TASKS : ent_back;

	// steal from the back of the chosen peer
	assign p_ne        = peer_front_q < peer_back_q;
	assign p_span      = peer_back_q - peer_front_q;
	assign steal_begin = (p_span > BURST_TASKS) ? peer_back_q - BURST_TASKS : peer_front_q;

	// one restoring division step of the launch split
	assign div_tmp = {rem_q, quo_q[TASK_W-1]};
	assign div_ge  = (div_tmp >= {1'b0, w});

	// split range of queue cnt, clipped at the total
	assign split_in_use   = ({1'b0, cnt_q[WID_W-1:0]} < w);
	assign split_end_full = acc_q + ACC_W'(per_q);
	assign split_begin    = (acc_q > ACC_W'(launch_total_q)) ? launch_total_q
	                        : acc_q[TASK_W-1:0];
	assign split_end      = (split_end_full > ACC_W'(launch_total_q)) ? launch_total_q
	                        : split_end_full[TASK_W-1:0];

	// status
	assign sts.is_launch  = (op_q == OP_LAUNCH);
	assign sts.id_ok      = ({1'b0, id_q} < w);
	assign sts.steal_on   = steal_enable;
	assign sts.own_empty  = !own_ne;
	assign sts.scan_end   = (cnt_q == w);
	assign sts.scan_self  = (cnt_q[WID_W-1:0] == id_q);
	assign sts.found      = found_q;
	assign sts.peer_big   = (ent_back > ent_front) && ((ent_back - ent_front) > BURST_TASKS);
	assign sts.div_last   = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign sts.split_last = (cnt_q == CNT_W'(MAX_WORKERS - 1));

	// memory access and grant decisions
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = cmd.rd_own | cmd.scan_rd;
		mem_addr  = id_q;
		mem_wdata = '0;
		set_given = 1'b0;
		set_done  = 1'b0;
		scan_init = 1'b0;
		res_load  = 1'b0;
		res_v     = 1'b0;
		res_b     = '0;
		res_e     = '0;
		res_s     = 1'b0;
		grant_add = 1'b0;
		grant_amt = '0;
		if (cmd.split_step || cmd.scan_rd) begin
			mem_addr = cnt_q[WID_W-1:0];
		end else if (cmd.steal_apply) begin
			mem_addr = peer_q;
		end
		if (cmd.split_step) begin
			mem_we    = 1'b1;
			mem_wdata = split_in_use ? {split_begin, split_end} : '0;
		end
		if (cmd.own_apply) begin
			if (!steal_enable) begin
				if (!given_q[id_q]) begin
					mem_we    = 1'b1;
					mem_wdata = {ent_back, ent_back};
					set_given = 1'b1;
					set_done  = 1'b1;
					res_load  = 1'b1;
					res_v     = own_ne;
					res_b     = own_ne ? ent_front : '0;
					res_e     = own_ne ? ent_back : '0;
					grant_add = own_ne;
					grant_amt = own_span;
				end
			end else if (own_ne) begin
				mem_we    = 1'b1;
				mem_wdata = {burst_end, ent_back};
				res_load  = 1'b1;
				res_v     = 1'b1;
				res_b     = ent_front;
				res_e     = burst_end;
				grant_add = 1'b1;
				grant_amt = burst_end - ent_front;
			end else begin
				set_done  = 1'b1;
				scan_init = 1'b1;
			end
		end
		if (cmd.steal_apply && p_ne) begin
			mem_we    = 1'b1;
			mem_wdata = {peer_front_q, steal_begin};
			res_load  = 1'b1;
			res_v     = 1'b1;
			res_b     = steal_begin;
			res_e     = peer_back_q;
			res_s     = 1'b1;
			grant_add = 1'b1;
			grant_amt = peer_back_q - steal_begin;
		end
	end

	// queue memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	// control state: counter, masks, valid bits, granted count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q          <= '0;
			found_q        <= 1'b0;
			done_q         <= '0;
			given_q        <= '0;
			granted_q      <= '0;
			launch_total_q <= '0;
			vld_q          <= '0;
			rvld_q         <= 1'b0;
		end else begin
			if (cmd.accept || cmd.split_init || scan_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step || cmd.split_step || cmd.scan_skip || cmd.scan_chk) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (scan_init) begin
				found_q <= 1'b0;
			end else if (cmd.scan_chk) begin
				found_q <= 1'b1;
			end
			if (cmd.split_init) begin
				done_q         <= '0;
				given_q        <= '0;
				granted_q      <= '0;
				launch_total_q <= task_count;
			end else begin
				if (set_done) begin
					done_q <= done_q | id_bit;
				end
				if (set_given) begin
					given_q <= given_q | id_bit;
				end
				if (grant_add) begin
					granted_q <= granted_q + GRANTED_W'(grant_amt);
				end
			end
			if (mem_we) begin
				vld_q[mem_addr] <= 1'b1;
			end
			if (mem_re) begin
				rvld_q <= vld_q[mem_addr];
			end
		end
	end

	// request capture, divider, split accumulator, peer latch, results
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q         <= op;
			id_q         <= worker_id;
			quo_q        <= task_count;
			rem_q        <= '0;
			res_valid_q  <= 1'b0;
			res_begin_q  <= '0;
			res_end_q    <= '0;
			res_stolen_q <= 1'b0;
		end
		if (cmd.div_step) begin
			quo_q <= {quo_q[TASK_W-2:0], div_ge};
			rem_q <= div_ge ? WCNT_W'(div_tmp - {1'b0, w}) : div_tmp[WCNT_W-1:0];
		end
		if (cmd.split_init) begin
			per_q <= quo_q + TASK_W'(rem_q != '0);
			acc_q <= '0;
		end
		if (cmd.split_step) begin
			acc_q <= split_end_full;
		end
		if (cmd.scan_chk) begin
			peer_q       <= cnt_q[WID_W-1:0];
			peer_front_q <= ent_front;
			peer_back_q  <= ent_back;
		end
		if (res_load) begin
			res_valid_q  <= res_v;
			res_begin_q  <= res_b;
			res_end_q    <= res_e;
			res_stolen_q <= res_s;
		end
		if (cmd.out_load) begin
			out_grant_q  <= res_valid_q;
			out_begin_q  <= res_begin_q;
			out_end_q    <= res_end_q;
			out_stolen_q <= res_stolen_q;
			out_done_q   <= (op_q == OP_REQUEST) && ((done_q & full_mask) == full_mask);
		end
	end

	assign grant_valid = out_grant_q;
	assign grant_begin = out_begin_q;
	assign grant_end   = out_end_q;
	assign stolen      = out_stolen_q;
	assign all_done    = out_done_q;

	// grants only carve up the launched range, so the count stays within it
	a_granted_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		granted_q <= GRANTED_W'(launch_total_q))
		else $error("granted task count exceeds launched total");

endmodule

/* rtl/work_stealing_range_dispatcher_core.sv */
// top level of the work-stealing range dispatcher: config registers, controller, datapath
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_ready   op, worker_id
//  out       output     out_valid / out_ready grant_valid, grant_begin, grant_end, stolen,
//                                             all_done
//  cfg       input      cfg_we                cfg_index, cfg_data
//
// an own-queue grant passes through the decode, own and finish states before its result
// shows; an unused id goes from decode straight to finish. a steal adds a scan that skips
// the own slot, reads and checks each peer in turn, stops at the first peer that holds more
// than a burst or after the last peer, and then takes the range. a launch runs 24 restoring
// division steps, then a 16-entry split sweep. one request is in flight; the next is accepted
// the cycle after a result is loaded, and a finished request waits while the output register
// is full and not taken. reset clears all queues at once through per-entry valid bits.
module work_stealing_range_dispatcher_core
	import wsrd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  op,
	input  logic [WID_W-1:0]      worker_id,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  grant_valid,
	output logic [TASK_W-1:0]     grant_begin,
	output logic [TASK_W-1:0]     grant_end,
	output logic                  stolen,
	output logic                  all_done,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [TASK_W-1:0]  task_count_q;
	logic [WCNT_W-1:0]  worker_count_q;
	logic               steal_enable_q;
	wsrd_cmd_t          cmd;
	wsrd_sts_t          sts;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q   <= '0;
			worker_count_q <= WCNT_W'(1);
			steal_enable_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TASK_COUNT:   task_count_q   <= cfg_data[TASK_W-1:0];
				REG_WORKER_COUNT: worker_count_q <= cfg_data[WCNT_W-1:0];
				REG_STEAL_ENABLE: steal_enable_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	wsrd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	wsrd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.worker_id    (worker_id),
		.task_count   (task_count_q),
		.worker_count (worker_count_q),
		.steal_enable (steal_enable_q),
		.grant_valid  (grant_valid),
		.grant_begin  (grant_begin),
		.grant_end    (grant_end),
		.stolen       (stolen),
		.all_done     (all_done)
	);

	// a granted range is never empty
	a_grant_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && grant_valid |-> grant_begin < grant_end)
		else $error("granted range is empty");

	// no grant carries no range and no steal flag
	a_no_grant_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !grant_valid |-> grant_begin == '0 && grant_end == '0 && !stolen)
		else $error("result without grant carries range data");

endmodule

/* bench/work_stealing_range_dispatcher_core_tb.sv */
// self-checking testbench of the work-stealing range dispatcher core
`timescale 1ns / 100ps

module work_stealing_range_dispatcher_core_tb;
	import wsrd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_PCT    = 23;

	// one grant result as the block presents it
	typedef struct packed {
		logic              granted;
		logic [TASK_W-1:0] first_task;
		logic [TASK_W-1:0] end_task;
		logic              stolen;
		logic              all_done;
	} grant_t;

	// dispatcher shadow: job registers, queue ranges and the grants still to come
	class grant_board;
		logic [TASK_W-1:0]      task_total;
		logic [4:0]             worker_reg;
		logic                   steal_on;
		logic [TASK_W-1:0]      q_front [MAX_WORKERS];
		logic [TASK_W-1:0]      q_back [MAX_WORKERS];
		logic [MAX_WORKERS-1:0] done_mask;
		logic [MAX_WORKERS-1:0] whole_given;
		logic [GRANTED_W-1:0]   granted_total;
		grant_t                 pending_grants[$];
		int mismatches, checked, launches, requests, grants, steals, done_flags;

		function new();
			task_total    = '0;
			worker_reg    = 5'd1;
			steal_on      = 1'b1;
			done_mask     = '0;
			whole_given   = '0;
			granted_total = '0;
			for (int i = 0; i < MAX_WORKERS; i++) begin
				q_front[i] = '0;
				q_back[i]  = '0;
			end
			mismatches = 0;
			checked    = 0;
			launches   = 0;
			requests   = 0;
			grants     = 0;
			steals     = 0;
			done_flags = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_TASK_COUNT:   task_total = val;
				REG_WORKER_COUNT: worker_reg = val[4:0];
				REG_STEAL_ENABLE: steal_on = val[0];
				default: ;
			endcase
		endfunction

		// zero workers count as one, more than the maximum saturate
		function int unsigned workers_active();
			if (worker_reg == 0) return 1;
			if (worker_reg > MAX_WORKERS) return MAX_WORKERS;
			return worker_reg;
		endfunction

		// work out the grant of one accepted request and update the queues
		function void take_request(logic o, logic [WID_W-1:0] id);
			int unsigned w, per, lo, hi, peer;
			bit found, stop;
			logic [31:0] full;
			grant_t r;
			w = workers_active();
			r = '0;
			if (o == OP_LAUNCH) begin
				// split into contiguous queues of ceiling(total / workers)
				launches++;
				per = (task_total + w - 1) / w;
				for (int unsigned p = 0; p < MAX_WORKERS; p++) begin
					lo = 0;
					hi = 0;
					if (p < w) begin
						lo = p * per;
						hi = lo + per;
						if (lo > task_total) lo = task_total;
						if (hi > task_total) hi = task_total;
					end
					q_front[p] = lo;
					q_back[p]  = hi;
				end
				done_mask     = '0;
				whole_given   = '0;
				granted_total = '0;
			end else if (id < w) begin
				requests++;
				if (!steal_on) begin
					// whole range, once per worker
					if (!whole_given[id]) begin
						r.first_task    = q_front[id];
						r.end_task      = q_back[id];
						r.granted       = q_front[id] < q_back[id];
						q_front[id]     = q_back[id];
						whole_given[id] = 1'b1;
						done_mask[id]   = 1'b1;
					end
				end else if (q_front[id] < q_back[id]) begin
					// burst from the front of the own queue
					r.first_task = q_front[id];
					r.end_task   = (q_back[id] - q_front[id] > BURST) ?
						q_front[id] + BURST_TASKS : q_back[id];
					q_front[id]  = r.end_task;
					r.granted    = 1'b1;
				end else begin
					// own queue empty: done, then steal from the back of a peer
					done_mask[id] = 1'b1;
					found = 1'b0;
					stop  = 1'b0;
					peer  = 0;
					for (int unsigned p = 0; p < w; p++) begin
						if (p != id && !stop) begin
							peer  = p;
							found = 1'b1;
							if (q_back[p] - q_front[p] > BURST) stop = 1'b1;
						end
					end
					if (found && q_front[peer] < q_back[peer]) begin
						r.end_task    = q_back[peer];
						r.first_task  = (q_back[peer] - q_front[peer] > BURST) ?
							q_back[peer] - BURST_TASKS : q_front[peer];
						q_back[peer]  = r.first_task;
						r.granted     = 1'b1;
						r.stolen      = 1'b1;
					end
				end
				if (r.granted) begin
					granted_total += GRANTED_W'(r.end_task - r.first_task);
					grants++;
					if (r.stolen) steals++;
				end else begin
					r = '0;
				end
			end else begin
				requests++;
			end
			if (o == OP_REQUEST) begin
				full = (32'd1 << w) - 32'd1;
				r.all_done = (done_mask & full[MAX_WORKERS-1:0]) == full[MAX_WORKERS-1:0];
				if (r.all_done) done_flags++;
			end
			pending_grants.push_back(r);
		endfunction

		// compare one delivered result with the oldest expected grant
		function void check_grant(logic gv, logic [TASK_W-1:0] gb, logic [TASK_W-1:0] ge,
			logic st, logic ad);
			grant_t want;
			checked++;
			if (pending_grants.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: valid %0b [%0d,%0d) stolen %0b done %0b",
						gv, gb, ge, st, ad);
				return;
			end
			want = pending_grants.pop_front();
			if (want.granted !== gv || want.first_task !== gb || want.end_task !== ge ||
				want.stolen !== st || want.all_done !== ad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result %0d: expected valid %0b [%0d,%0d) stolen %0b done %0b",
						checked, want.granted, want.first_task, want.end_task,
						want.stolen, want.all_done);
					$display("result %0d:      got valid %0b [%0d,%0d) stolen %0b done %0b",
						checked, gv, gb, ge, st, ad);
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  op;
	logic [WID_W-1:0]      worker_id;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  grant_valid;
	logic [TASK_W-1:0]     grant_begin;
	logic [TASK_W-1:0]     grant_end;
	logic                  stolen;
	logic                  all_done;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	grant_board board;
	bit calm = 1'b0;
	int hold_asked = 0;
	int hold_served = 0;
	int hold_left = 0;
	int cycles = 0;
	int job_settings = 0;

	work_stealing_range_dispatcher_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.worker_id   (worker_id),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.grant_valid (grant_valid),
		.grant_begin (grant_begin),
		.grant_end   (grant_end),
		.stolen      (stolen),
		.all_done    (all_done),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: check each accepted grant, random stalls and one long hold-off
	always @(posedge clk) begin
		if (out_valid && out_ready)
			board.check_grant(grant_valid, grant_begin, grant_end, stolen, all_done);
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_served < hold_asked) begin
			hold_served++;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// offer one request and wait for it to be taken; called at a rising edge
	task automatic send_request(input logic o, input logic [WID_W-1:0] id);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= o;
		worker_id <= id;
		do @(posedge clk); while (!in_ready);
		board.take_request(o, id);
	endtask

	// write all three job registers, one per cycle
	task automatic set_job(input logic [TASK_W-1:0] tc, input logic [4:0] wc, input logic se);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TASK_COUNT;
		cfg_data  <= tc;
		board.write_register(REG_TASK_COUNT, tc);
		@(posedge clk);
		cfg_index <= REG_WORKER_COUNT;
		cfg_data  <= CFG_DATA_W'(wc);
		board.write_register(REG_WORKER_COUNT, CFG_DATA_W'(wc));
		@(posedge clk);
		cfg_index <= REG_STEAL_ENABLE;
		cfg_data  <= CFG_DATA_W'(se);
		board.write_register(REG_STEAL_ENABLE, CFG_DATA_W'(se));
		@(posedge clk);
		cfg_we <= 1'b0;
		job_settings++;
	endtask

	// stop offering and let every outstanding grant come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (board.pending_grants.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int random_items, phase, len, pick;
		int unsigned weff;
		logic [4:0] wc;
		logic [TASK_W-1:0] tc;
		logic se;
		bit resume;

		board     = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		op        = OP_LAUNCH;
		worker_id = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_TASK_COUNT;
		cfg_data  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// request before any launch, reset register values
		send_request(OP_REQUEST, 4'd0);
		wait_idle();

		// zero workers counts as one
		set_job(24'd0, 5'd0, 1'b1);
		send_request(OP_LAUNCH, 4'd15);
		send_request(OP_REQUEST, 4'd0);
		wait_idle();

		// three small queues: own burst, unused worker, steal from last peer, empty steal
		set_job(24'd300, 5'd3, 1'b1);
		send_request(OP_LAUNCH, 4'd0);
		send_request(OP_REQUEST, 4'd0);
		send_request(OP_REQUEST, 4'd3);
		send_request(OP_REQUEST, 4'd0);
		send_request(OP_REQUEST, 4'd1);
		send_request(OP_REQUEST, 4'd2);
		wait_idle();

		// largest task count, worker count above the maximum
		set_job(24'hFFFFFF, 5'd31, 1'b1);
		send_request(OP_LAUNCH, 4'd7);
		send_request(OP_REQUEST, 4'd15);
		wait_idle();

		// stealing switched off mid-job: rest of the range once, then nothing
		set_job(24'hFFFFFF, 5'd31, 1'b0);
		send_request(OP_REQUEST, 4'd15);
		send_request(OP_REQUEST, 4'd15);
		wait_idle();

		// more workers than tasks, whole ranges, empty range
		set_job(24'd5, 5'd17, 1'b0);
		send_request(OP_LAUNCH, 4'd9);
		send_request(OP_REQUEST, 4'd4);
		send_request(OP_REQUEST, 4'd9);
		send_request(OP_REQUEST, 4'd4);
		wait_idle();

		// stealing switched back on mid-job
		set_job(24'd5, 5'd17, 1'b1);
		send_request(OP_REQUEST, 4'd0);
		send_request(OP_REQUEST, 4'd9);
		wait_idle();

		// two workers run dry until everyone is done
		set_job(24'd10, 5'd2, 1'b1);
		send_request(OP_LAUNCH, 4'd1);
		send_request(OP_REQUEST, 4'd0);
		send_request(OP_REQUEST, 4'd1);
		send_request(OP_REQUEST, 4'd0);
		send_request(OP_REQUEST, 4'd1);
		wait_idle();

		// random jobs: mostly launch then requests from workers in use
		random_items = 0;
		phase = 0;
		while (random_items < 400) begin
			calm = (phase == 3);
			if (phase == 1) hold_asked++;
			wc = ($urandom_range(99) < 80) ? 5'($urandom_range(16, 1)) :
				5'($urandom_range(31, 0));
			weff = (wc == 0) ? 1 : ((wc > MAX_WORKERS) ? MAX_WORKERS : wc);
			tc = ($urandom_range(99) < 90) ? TASK_W'($urandom_range(weff * BURST * 2, 0)) :
				TASK_W'($urandom);
			se = ($urandom_range(99) < 80);
			resume = (phase != 0) && ($urandom_range(99) < 15);
			set_job(tc, wc, se);
			len = (phase == 1) ? 40 : $urandom_range(40, 10);
			if (!resume) begin
				send_request(OP_LAUNCH, WID_W'($urandom));
				random_items++;
			end
			repeat (len) begin
				pick = $urandom_range(99);
				if (pick < 4)
					send_request(OP_LAUNCH, WID_W'($urandom));
				else if (pick < 12)
					send_request(OP_REQUEST, WID_W'($urandom));
				else
					send_request(OP_REQUEST, WID_W'($urandom_range(weff - 1, 0)));
				random_items++;
			end
			wait_idle();
			phase++;
		end
		calm = 1'b0;

		// allow any stray result to show up
		repeat (60) @(posedge clk);

		$display("covered %0d launches and %0d work requests over %0d job settings",
			board.launches, board.requests, job_settings);
		$display("%0d ranges granted, %0d stolen, %0d results with all workers done",
			board.grants, board.steals, board.done_flags);
		if (board.mismatches == 0 && board.pending_grants.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
